[rtl/fgcs_pkg.sv]
// Package for the flat grinding cycle sequencer.
// Holds the transaction payload types, phase/function/error codes and CSR indexes.
// No dependencies; every other file uses it by scoped names.
package fgcs_pkg;

   localparam int unsigned PosWidth  = 32;
   localparam int unsigned StepWidth = 31;
   localparam int unsigned CsrIdxWidth = 3;

   // Request transaction: one control tick
   typedef struct packed {
      logic [1:0]                 func;
      logic                       x_homed;
      logic                       at_start;
      logic                       x_done;
      logic                       y_done;
      logic                       z_done;
      logic signed [PosWidth-1:0] z_position_nm;
   } req_data_type;

   // Response transaction: axis commands and status for one tick
   typedef struct packed {
      logic                       x_move;
      logic signed [PosWidth-1:0] x_target_nm;
      logic                       x_grind_speed;
      logic                       y_move;
      logic signed [PosWidth-1:0] y_target_nm;
      logic                       z_move;
      logic signed [PosWidth-1:0] z_target_nm;
      logic                       stop_all;
      logic [3:0]                 phase_now;
      logic                       running;
      logic [1:0]                 error_code;
   } rsp_data_type;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_RESET  = 2'd1,
      FUNC_CANCEL = 2'd2,
      FUNC_UNUSED = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_NOT_HOMED = 2'd1,
      ERR_LIMITS    = 2'd2
   } err_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_X_START      = 3'd0,
      CSR_X_END        = 3'd1,
      CSR_Z_START      = 3'd2,
      CSR_Z_END        = 3'd3,
      CSR_Y_WORK       = 3'd4,
      CSR_Y_SAFE       = 3'd5,
      CSR_STEPOVER     = 3'd6,
      CSR_LIMITS_VALID = 3'd7
   } csr_idx_type;

   // Cycle phases, one-hot
   typedef enum logic [9:0] {
      PH_INITIAL     = 10'b00_0000_0001,
      PH_RISE        = 10'b00_0000_0010,
      PH_TO_START    = 10'b00_0000_0100,
      PH_LOWER       = 10'b00_0000_1000,
      PH_GRIND_END   = 10'b00_0001_0000,
      PH_ADV_END     = 10'b00_0010_0000,
      PH_GRIND_START = 10'b00_0100_0000,
      PH_ADV_START   = 10'b00_1000_0000,
      PH_REWIND      = 10'b01_0000_0000,
      PH_FINAL       = 10'b10_0000_0000
   } phase_type;

   // Reported phase number for a one-hot phase
   function automatic logic [3:0] phase_code(input phase_type ph);
      logic [3:0] code;
      unique case (ph)
         PH_INITIAL:     code = 4'd0;
         PH_RISE:        code = 4'd1;
         PH_TO_START:    code = 4'd2;
         PH_LOWER:       code = 4'd3;
         PH_GRIND_END:   code = 4'd4;
         PH_ADV_END:     code = 4'd5;
         PH_GRIND_START: code = 4'd6;
         PH_ADV_START:   code = 4'd7;
         PH_REWIND:      code = 4'd8;
         PH_FINAL:       code = 4'd9;
         default:        code = 4'd0;
      endcase
      return code;
   endfunction

endpackage

[rtl/fgcs_ifs.sv]
// Channel interfaces for the flat grinding cycle sequencer.
// Request, response and CSR write channels; payload types from fgcs_pkg.
interface fgcs_req_if;
   logic                  valid;
   logic                  ready;
   fgcs_pkg::req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fgcs_rsp_if;
   logic                  valid;
   logic                  ready;
   fgcs_pkg::rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fgcs_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [fgcs_pkg::CsrIdxWidth-1:0]      index;
   logic [fgcs_pkg::PosWidth-1:0]         wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/flat_grind_cycle_sequencer_top.sv]
// Flat grinding cycle sequencer, top level.
// Uses fgcs_pkg and the channel interfaces in fgcs_ifs.sv.
//
// Takes one control tick per clock while responses are taken and returns one
// response per tick, in order. A tick is captured in an input register; the
// phase decision and the Z advance (one 33-bit subtract with a clamp to the
// stepover) are evaluated from it and loaded into the result register, which
// presents the response. Both registers move together when the response side
// drains, so a transaction can be accepted every cycle while responses are
// taken; a response stall holds both stages. CSR writes are always accepted
// and should be made while idle.
module flat_grind_cycle_sequencer_top (
   input  logic              clock,
   input  logic              reset,
   fgcs_req_if.sink          req_chan,
   fgcs_rsp_if.source        rsp_chan,
   fgcs_csr_if.sink          csr_chan
);

   // Configuration registers
   logic signed [fgcs_pkg::PosWidth-1:0]  x_start_ff, x_end_ff, z_start_ff, z_end_ff;
   logic signed [fgcs_pkg::PosWidth-1:0]  y_work_ff, y_safe_ff;
   logic [fgcs_pkg::StepWidth-1:0]        stepover_ff;
   logic                                  limits_valid_ff;

   // Pipeline registers
   logic                   s1_valid_ff, s1_valid_in;
   fgcs_pkg::req_data_type s1_data_ff;
   logic                   s2_valid_ff, s2_valid_in;
   fgcs_pkg::rsp_data_type s2_data_ff, s2_data_in;
   logic                   s1_advance;

   // Sequencer state
   fgcs_pkg::phase_type    phase_ff, phase_in;
   fgcs_pkg::err_type      err_ff, err_in;

   // Z advance datapath
   logic signed [fgcs_pkg::PosWidth:0]    z_diff, step_pos, step_neg, z_adv;
   logic signed [fgcs_pkg::PosWidth-1:0]  z_adv_target;
   logic                                  z_adv_zero;

   // CSR writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff      <= '0;
         x_end_ff        <= '0;
         z_start_ff      <= '0;
         z_end_ff        <= '0;
         y_work_ff       <= '0;
         y_safe_ff       <= '0;
         stepover_ff     <= '0;
         limits_valid_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (fgcs_pkg::csr_idx_type'(csr_chan.index))
            fgcs_pkg::CSR_X_START:      x_start_ff      <= csr_chan.wdata;
            fgcs_pkg::CSR_X_END:        x_end_ff        <= csr_chan.wdata;
            fgcs_pkg::CSR_Z_START:      z_start_ff      <= csr_chan.wdata;
            fgcs_pkg::CSR_Z_END:        z_end_ff        <= csr_chan.wdata;
            fgcs_pkg::CSR_Y_WORK:       y_work_ff       <= csr_chan.wdata;
            fgcs_pkg::CSR_Y_SAFE:       y_safe_ff       <= csr_chan.wdata;
            fgcs_pkg::CSR_STEPOVER:     stepover_ff     <= csr_chan.wdata[fgcs_pkg::StepWidth-1:0];
            fgcs_pkg::CSR_LIMITS_VALID: limits_valid_ff <= csr_chan.wdata[0];
            default: ;
         endcase
      end
   end

   // Handshake: stage 1 drains into stage 2 when stage 2 is free or emptying
   assign s1_advance     = s1_valid_ff && (!s2_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign s1_valid_in    = req_chan.valid ? 1'b1 : (s1_valid_ff && !s1_advance);
   assign s2_valid_in    = s1_advance ? 1'b1 : (s2_valid_ff && !rsp_chan.ready);

   // Z advance: (Z end - Z position) at 33 bits, clamped to +/- stepover
   always_comb begin
      z_diff   = {z_end_ff[fgcs_pkg::PosWidth-1], z_end_ff}
               - {s1_data_ff.z_position_nm[fgcs_pkg::PosWidth-1], s1_data_ff.z_position_nm};
      step_pos = {2'b00, stepover_ff};
      step_neg = -step_pos;
      if (z_diff > step_pos) begin
         z_adv = step_pos;
      end else if (z_diff < step_neg) begin
         z_adv = step_neg;
      end else begin
         z_adv = z_diff;
      end
      z_adv_zero   = (z_adv == '0);
      z_adv_target = s1_data_ff.z_position_nm + z_adv[fgcs_pkg::PosWidth-1:0];
   end

   // Phase decision for the transaction in stage 1
   always_comb begin
      phase_in   = phase_ff;
      err_in     = err_ff;
      s2_data_in = '0;
      case (fgcs_pkg::func_type'(s1_data_ff.func))
         fgcs_pkg::FUNC_RESET: begin
            err_in   = fgcs_pkg::ERR_NONE;
            phase_in = fgcs_pkg::PH_INITIAL;
         end
         fgcs_pkg::FUNC_CANCEL: begin
            s2_data_in.stop_all = 1'b1;
         end
         fgcs_pkg::FUNC_TICK: begin
            if (!s1_data_ff.x_homed) begin
               err_in = fgcs_pkg::ERR_NOT_HOMED;
            end else if (!limits_valid_ff) begin
               err_in = fgcs_pkg::ERR_LIMITS;
            end else if (phase_ff != fgcs_pkg::PH_FINAL) begin
               s2_data_in.running = 1'b1;
               unique case (phase_ff)
                  fgcs_pkg::PH_INITIAL: begin
                     if (s1_data_ff.at_start) begin
                        s2_data_in.x_move      = 1'b1;
                        s2_data_in.x_target_nm = x_start_ff;
                        s2_data_in.z_move      = 1'b1;
                        s2_data_in.z_target_nm = z_start_ff;
                        phase_in               = fgcs_pkg::PH_TO_START;
                     end else begin
                        s2_data_in.y_move      = 1'b1;
                        s2_data_in.y_target_nm = y_safe_ff;
                        phase_in               = fgcs_pkg::PH_RISE;
                     end
                  end
                  fgcs_pkg::PH_RISE: begin
                     if (s1_data_ff.y_done) begin
                        s2_data_in.x_move      = 1'b1;
                        s2_data_in.x_target_nm = x_start_ff;
                        s2_data_in.z_move      = 1'b1;
                        s2_data_in.z_target_nm = z_start_ff;
                        phase_in               = fgcs_pkg::PH_TO_START;
                     end
                  end
                  fgcs_pkg::PH_TO_START: begin
                     if (s1_data_ff.x_done && s1_data_ff.z_done) begin
                        s2_data_in.y_move      = 1'b1;
                        s2_data_in.y_target_nm = y_work_ff;
                        phase_in               = fgcs_pkg::PH_LOWER;
                     end
                  end
                  fgcs_pkg::PH_LOWER, fgcs_pkg::PH_ADV_START: begin
                     if ((phase_ff == fgcs_pkg::PH_LOWER) ? s1_data_ff.y_done
                                                          : s1_data_ff.z_done) begin
                        s2_data_in.x_move        = 1'b1;
                        s2_data_in.x_grind_speed = 1'b1;
                        s2_data_in.x_target_nm   = x_end_ff;
                        phase_in                 = fgcs_pkg::PH_GRIND_END;
                     end
                  end
                  fgcs_pkg::PH_GRIND_END: begin
                     if (s1_data_ff.x_done) begin
                        if (z_adv_zero) begin
                           // nothing left to feed: go straight into the return pass
                           s2_data_in.x_move        = 1'b1;
                           s2_data_in.x_grind_speed = 1'b1;
                           s2_data_in.x_target_nm   = x_start_ff;
                           phase_in                 = fgcs_pkg::PH_GRIND_START;
                        end else begin
                           s2_data_in.z_move      = 1'b1;
                           s2_data_in.z_target_nm = z_adv_target;
                           phase_in               = fgcs_pkg::PH_ADV_END;
                        end
                     end
                  end
                  fgcs_pkg::PH_ADV_END: begin
                     if (s1_data_ff.z_done) begin
                        s2_data_in.x_move        = 1'b1;
                        s2_data_in.x_grind_speed = 1'b1;
                        s2_data_in.x_target_nm   = x_start_ff;
                        phase_in                 = fgcs_pkg::PH_GRIND_START;
                     end
                  end
                  fgcs_pkg::PH_GRIND_START: begin
                     if (s1_data_ff.x_done) begin
                        s2_data_in.z_move = 1'b1;
                        if (z_adv_zero) begin
                           // done feeding: rewind Z
                           s2_data_in.z_target_nm = z_start_ff;
                           phase_in               = fgcs_pkg::PH_REWIND;
                        end else begin
                           s2_data_in.z_target_nm = z_adv_target;
                           phase_in               = fgcs_pkg::PH_ADV_START;
                        end
                     end
                  end
                  fgcs_pkg::PH_REWIND: begin
                     if (s1_data_ff.z_done) begin
                        phase_in = fgcs_pkg::PH_FINAL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      s2_data_in.phase_now  = fgcs_pkg::phase_code(phase_in);
      s2_data_in.error_code = err_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         phase_ff    <= fgcs_pkg::PH_INITIAL;
         err_ff      <= fgcs_pkg::ERR_NONE;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s1_advance) begin
            phase_ff <= phase_in;
            err_ff   <= err_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_data_ff <= req_chan.data;
      end
      if (s1_advance) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign rsp_chan.valid = s2_valid_ff;
   assign rsp_chan.data  = s2_data_ff;

endmodule

[rtl/fgcs_checker.sv]
// Port-level checker for the flat grinding cycle sequencer, with its bind.
// Watches the response channel of flat_grind_cycle_sequencer_top; uses fgcs_pkg.
module fgcs_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input fgcs_pkg::rsp_data_type rsp_data
);

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Stop command never comes with a move or a running cycle
   a_stop_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stop_all |->
         !rsp_data.running && !rsp_data.x_move && !rsp_data.y_move && !rsp_data.z_move)
      else $error("stop_all with move or running");

   // A running tick always leaves the initial phase
   a_run_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.running |->
         rsp_data.phase_now != fgcs_pkg::phase_code(fgcs_pkg::PH_INITIAL))
      else $error("running reported in initial phase");

   // Idle axes show zero targets and traverse speed
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.x_move || (rsp_data.x_target_nm == '0 && !rsp_data.x_grind_speed)) &&
         (rsp_data.y_move || rsp_data.y_target_nm == '0) &&
         (rsp_data.z_move || rsp_data.z_target_nm == '0))
      else $error("idle axis carries a target");

endmodule

bind flat_grind_cycle_sequencer_top fgcs_checker u_fgcs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
